// ----- design/bmrq_pkg.sv -----
// Package for the bracket match range query block.
// Types, constants and the span merge function; no dependencies.
package bmrq_pkg;
  localparam int STRING_LENGTH_DEF = 1024;
  localparam int POS_W = 10;
  localparam int CNT_W = 11;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;
  localparam logic [1:0] BR_OPEN  = 2'd1;
  localparam logic [1:0] BR_CLOSE = 2'd2;

  typedef struct packed {
    logic             opcode;
    logic [POS_W-1:0] position;
    logic [1:0]       bracket;
    logic [POS_W-1:0] range_low;
    logic [POS_W-1:0] range_high;
  } in_item_t;

  typedef struct packed {
    logic [9:0]  matched_pairs;
    logic [10:0] match_length;
    logic        range_error;
  } out_item_t;

  typedef struct packed {
    logic [CNT_W-1:0] open_cnt;
    logic [CNT_W-1:0] pairs;
    logic [CNT_W-1:0] close_cnt;
  } span_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_WLEAF, ST_WREAD, ST_WJOIN, ST_QREAD, ST_QJOIN, ST_CLEAR, ST_OUT
  } state_t;

  typedef struct packed {
    logic clr;       // zero one node pair after reset
    logic load;      // capture input item
    logic wleaf;     // write leaf
    logic wread;     // issue child reads
    logic wjoin;     // write joined parent, step up
    logic qread;     // issue reads for query level
    logic qjoin;     // accumulate, step up
    logic fin;       // form result
  } cmd_t;

  typedef struct packed {
    logic clr_done;  // last node pair cleared
    logic is_query;
    logic bad;
    logic at_root;   // write walk finished
    logic q_done;    // l >= r
  } sts_t;

  function automatic span_t join_spans(span_t a, span_t b);
    logic [CNT_W-1:0] m;
    span_t r;
    m = (a.open_cnt < b.close_cnt) ? a.open_cnt : b.close_cnt;
    r.open_cnt  = a.open_cnt + b.open_cnt - m;
    r.close_cnt = a.close_cnt + b.close_cnt - m;
    r.pairs     = a.pairs + b.pairs + m;
    return r;
  endfunction
endpackage

// ----- design/bmrq_ctrl.sv -----
// Controller state machine for the bracket match range query block.
// Depends on bmrq_pkg.
module bmrq_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  bmrq_pkg::sts_t sts,
  output bmrq_pkg::cmd_t cmd
);
  import bmrq_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_CLEAR;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = ST_WLEAF;
        end
      end
      ST_WLEAF: begin
        if (sts.bad) state_nxt = ST_OUT;
        else if (sts.is_query) state_nxt = ST_QREAD;
        else begin
          cmd.wleaf = 1'b1;
          state_nxt = ST_WREAD;
        end
      end
      ST_WREAD: begin
        if (sts.at_root) state_nxt = ST_IDLE;
        else begin
          cmd.wread = 1'b1;
          state_nxt = ST_WJOIN;
        end
      end
      ST_WJOIN: begin
        cmd.wjoin = 1'b1;
        state_nxt = ST_WREAD;
      end
      ST_QREAD: begin
        if (sts.q_done) begin
          cmd.fin = 1'b1;
          state_nxt = ST_OUT;
        end else begin
          cmd.qread = 1'b1;
          state_nxt = ST_QJOIN;
        end
      end
      ST_QJOIN: begin
        cmd.qjoin = 1'b1;
        state_nxt = ST_QREAD;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule

// ----- design/bmrq_dp.sv -----
// Datapath for the bracket match range query block: node memories, walk
// indexes and accumulators. Depends on bmrq_pkg.
module bmrq_dp #(
  parameter int STRING_LENGTH = bmrq_pkg::STRING_LENGTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bmrq_pkg::in_item_t  in_data,
  input  bmrq_pkg::cmd_t      cmd,
  output bmrq_pkg::sts_t      sts,
  output bmrq_pkg::out_item_t out_data
);
  import bmrq_pkg::*;

  localparam int LW = $clog2(STRING_LENGTH);
  localparam int NW = LW + 2;            // holds 2*STRING_LENGTH
  localparam int AW = $clog2(2 * STRING_LENGTH);
  localparam logic [NW-1:0] SL = NW'(STRING_LENGTH);

  // Two banks: even (left child) and odd (right child) nodes.
  localparam int BD = STRING_LENGTH;
  localparam int BW = (BD > 1) ? $clog2(BD) : 1;

  span_t mem_e [BD];
  span_t mem_o [BD];
  span_t rd_e_r, rd_o_r;
  logic [BW-1:0] clr_r;

  in_item_t  item_r;
  logic [NW-1:0] k_r, l_r, r_r;
  span_t accl_r, accr_r;
  logic  bad_r;
  logic  take_l_r, take_r_r;
  out_item_t res_r;

  logic [NW-1:0] pos_ext, lo_ext, hi_ext;
  logic bad_c;
  span_t leaf, e_val, o_val, joined, tot;
  logic [NW-1:0] r_dec;

  assign pos_ext = NW'(item_r.position);
  assign lo_ext  = NW'(item_r.range_low);
  assign hi_ext  = NW'(item_r.range_high);
  assign bad_c = (item_r.opcode == OP_WRITE) ? (pos_ext >= SL)
               : ((lo_ext > hi_ext) || (hi_ext >= SL));

  assign leaf.open_cnt  = (item_r.bracket == BR_OPEN) ? CNT_W'(1) : '0;
  assign leaf.close_cnt = (item_r.bracket == BR_CLOSE) ? CNT_W'(1) : '0;
  assign leaf.pairs = '0;

  assign e_val = rd_e_r;
  assign o_val = rd_o_r;
  assign joined = join_spans(e_val, o_val);
  assign tot = join_spans(accl_r, accr_r);
  assign r_dec = r_r - NW'(1);

  assign sts.clr_done = (clr_r == BW'(BD - 1));
  assign sts.is_query = item_r.opcode;
  assign sts.bad = bad_c;
  assign sts.at_root = (k_r == '0);
  assign sts.q_done = !(l_r < r_r);

  logic wr_en;
  logic [AW-1:0] wr_addr;
  span_t wr_data;
  logic [AW-1:0] ra_e, ra_o;

  always_comb begin
    wr_en = cmd.wleaf || cmd.wjoin;
    wr_addr = cmd.wleaf ? AW'(pos_ext + SL) : AW'(k_r);
    wr_data = cmd.wleaf ? leaf : joined;
    if (cmd.wread) begin
      ra_e = AW'({k_r[NW-2:0], 1'b0});
      ra_o = AW'({k_r[NW-2:0], 1'b1});
    end else begin
      ra_e = AW'(r_dec);
      ra_o = AW'(l_r);
    end
  end

  // l odd -> odd bank; r-1 even when r odd -> even bank.
  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      mem_e[clr_r] <= '0;
      mem_o[clr_r] <= '0;
    end else begin
      if (wr_en && !wr_addr[0]) mem_e[wr_addr[AW-1:1]] <= wr_data;
      if (wr_en && wr_addr[0])  mem_o[wr_addr[AW-1:1]] <= wr_data;
    end
    rd_e_r <= mem_e[ra_e[AW-1:1]];
    rd_o_r <= mem_o[ra_o[AW-1:1]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) clr_r <= '0;
    else if (cmd.clr) clr_r <= clr_r + BW'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_data;
    if (cmd.wleaf) k_r <= (pos_ext + SL) >> 1;
    if (cmd.wjoin) k_r <= k_r >> 1;
    if (cmd.load) begin
      l_r <= NW'(in_data.range_low) + SL;
      r_r <= NW'(in_data.range_high) + SL + NW'(1);
      accl_r <= '0;
      accr_r <= '0;
      k_r <= '0;
    end
    if (cmd.qread) begin
      take_l_r <= l_r[0];
      take_r_r <= r_r[0];
    end
    if (cmd.qjoin) begin
      if (take_l_r) accl_r <= join_spans(accl_r, o_val);
      if (take_r_r) accr_r <= join_spans(e_val, accr_r);
      l_r <= (l_r + NW'(take_l_r)) >> 1;
      r_r <= (r_r - NW'(take_r_r)) >> 1;
    end
    bad_r <= bad_c;
    if (cmd.load) begin
      res_r <= '0;
    end else if (cmd.fin) begin
      res_r.matched_pairs <= tot.pairs[9:0];
      res_r.match_length <= {tot.pairs[9:0], 1'b0};
      res_r.range_error <= 1'b0;
    end
  end

  always_comb begin
    out_data = res_r;
    if (bad_r) begin
      out_data = '0;
      out_data.range_error = 1'b1;
    end
  end
endmodule

// ----- design/bracket_match_range_query_top.sv -----
// Top level of the bracket match range query block.
// Instantiates bmrq_ctrl and bmrq_dp; depends on bmrq_pkg.
//
// Usage:
//   One input channel (in_valid/in_stall/in_data) takes write and query
//   transactions; one output channel (out_valid/out_stall/out_data)
//   returns a result for each query and for each rejected write.
//   A write sets one leaf of a segment tree held in two node memories
//   (even and odd children) and rewalks its ancestors, one child read and
//   one parent write per level.
//   A query walks up from both range ends, one memory read and one merge
//   per level, until the ends meet; one transaction is in work at a time.
//   Rejected items skip the walk and go straight to the result state.
//   After reset a clearing pass zeroes the tree, one node pair per cycle,
//   all STRING_LENGTH node pairs, with the input stalled.
//   While out_stall is high the result holds and no new transaction is
//   accepted.
module bracket_match_range_query_top #(
  parameter int STRING_LENGTH = bmrq_pkg::STRING_LENGTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  bmrq_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output bmrq_pkg::out_item_t out_data
);
  import bmrq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bmrq_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
    .sts, .cmd
  );

  bmrq_dp #(.STRING_LENGTH(STRING_LENGTH)) u_dp (
    .clk, .rst_n, .in_data, .cmd, .sts, .out_data
  );

  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.match_length == {out_data.matched_pairs, 1'b0})
    else $error("match_length not twice pairs");
  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.range_error |-> out_data.matched_pairs == '0)
    else $error("error result carries counts");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open while result pending");
endmodule
